@@ sv/pcm_volume_and_rate_doubler_top_defines.svh @@
// Assertion macros shared by the RTL of the volume scaler and sample repeater.
// Depends on nothing; included by the files that carry assertions.
`ifndef PCM_VOLUME_AND_RATE_DOUBLER_TOP_DEFINES_SVH
`define PCM_VOLUME_AND_RATE_DOUBLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PVRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PVRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pvrd_pkg.sv @@
// Package of the volume scaler and sample repeater: widths, register indexes,
// rate codes, Q15 factor constants and shared types. Depends on nothing.
package pvrd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int Q15_SHIFT    = 15;
    localparam int Q15_ONE      = 32768;
    localparam int PERCENT_FULL = 100;

    localparam int VOL_W    = 7;
    localparam int IDX_W    = 2;
    localparam int FACTOR_W = Q15_SHIFT + 1;
    localparam int PROD_W   = SAMPLE_WIDTH + FACTOR_W + 1;
    localparam int REP_W    = 2;

    localparam logic [IDX_W-1:0] CFG_VOLUME   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CHANNELS = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RATE     = 2'd2;

    localparam logic [1:0] RATE_44K1   = 2'd0;
    localparam logic [1:0] RATE_22K05  = 2'd1;
    localparam logic [1:0] RATE_11K025 = 2'd2;

    localparam logic [1:0] CHAN_MONO = 2'd1;

    // Repeat counts held as count minus one
    localparam logic [REP_W-1:0] REP_ONE  = 2'd0;
    localparam logic [REP_W-1:0] REP_TWO  = 2'd1;
    localparam logic [REP_W-1:0] REP_FOUR = 2'd3;

    localparam logic [VOL_W-1:0] VOL_MAX = VOL_W'(PERCENT_FULL);
    localparam logic [VOL_W-1:0] VOL_RST = 7'd80;
    localparam logic [FACTOR_W-1:0] FACTOR_RST =
        FACTOR_W'(80 * Q15_ONE / PERCENT_FULL);

    // floor(v*32768/100) = v*327 + floor(v*17/25); the last term by reciprocal
    localparam int FINE_PROD_W = VOL_W + 16;
    localparam int VOL_COARSE  = 327;
    localparam int VOL_FINE    = 17 * 2622;
    localparam int FINE_SHIFT  = 16;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_pair;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic                mono;
        logic [REP_W-1:0]    rep_last;
    } t_cfg;

endpackage

@@ sv/pvrd_if.sv @@
// Handshake interfaces of the volume scaler: input frames, output frames and
// register writes. Depends on pvrd_pkg.
interface pvrd_in_if;
    logic              valid;
    logic              ready;
    pvrd_pkg::t_sample left_sample;
    pvrd_pkg::t_sample right_sample;
    logic              end_of_block;

    modport source(output valid, left_sample, right_sample, end_of_block, input ready);
    modport sink(input valid, left_sample, right_sample, end_of_block, output ready);
endinterface

interface pvrd_out_if;
    logic              valid;
    logic              ready;
    pvrd_pkg::t_sample left_out;
    pvrd_pkg::t_sample right_out;
    logic              run_last;
    logic              block_end;

    modport source(output valid, left_out, right_out, run_last, block_end, input ready);
    modport sink(input valid, left_out, right_out, run_last, block_end, output ready);
endinterface

interface pvrd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pvrd_pkg::IDX_W-1:0]   index;
    logic [pvrd_pkg::VOL_W-1:0]   data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ sv/pcm_volume_and_rate_doubler_top.sv @@
// Top level of the volume scaler and sample repeater: registers, input stage,
// Q15 scaler and repeating result register. Depends on pvrd_pkg, pvrd_if and
// the pvrd_* modules.
//
//   channel  | dir | payload                                    | accepted when
//   i_in     | in  | left_sample, right_sample, end_of_block    | valid && ready
//   o_out    | out | left_out, right_out, run_last, block_end    | valid && ready
//   i_cfg    | in  | index (0 volume, 1 channels, 2 rate), data | valid && ready
//
// A frame passes from the input register through the scaler into the result
// register and is shown there 1, 2 or 4 times (rate code 0 or 3, 1, 2), set by
// the repeat counter there. i_cfg is always ready.
// One new frame enters every cycle at one output per frame while o_out is ready.
// A stall on o_out holds the result register and, once the input register
// is full, i_in. Synchronous reset restores volume 80, stereo and one output per frame.
module pcm_volume_and_rate_doubler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pvrd_in_if.sink     i_in,
    pvrd_out_if.source  o_out,
    pvrd_cfg_if.sink    i_cfg
);

    pvrd_pkg::t_cfg  w_cfg;
    pvrd_pkg::t_pair w_raw;
    pvrd_pkg::t_pair w_scaled;

    pvrd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    pvrd_scale u_scale (
        .i_pair   (w_raw),
        .i_factor (w_cfg.factor),
        .o_pair   (w_scaled)
    );

    pvrd_rep u_rep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (w_cfg),
        .o_raw    (w_raw),
        .i_scaled (w_scaled)
    );

endmodule

@@ sv/pvrd_cfg.sv @@
// Register file of the volume scaler: saturates volume writes and holds the
// Q15 factor, mono flag and repeat count. Depends on pvrd_pkg and pvrd_if.
module pvrd_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pvrd_cfg_if.sink             i_cfg,
    output pvrd_pkg::t_cfg       o_cfg
);

    logic [pvrd_pkg::VOL_W-1:0]       w_vol;
    logic [pvrd_pkg::FINE_PROD_W-1:0] w_fine;
    logic [pvrd_pkg::FACTOR_W-1:0]    w_coarse;
    logic [pvrd_pkg::FACTOR_W-1:0]    n_factor;
    logic [pvrd_pkg::FACTOR_W-1:0]    r_factor;
    logic                             n_mono;
    logic                             r_mono;
    logic [pvrd_pkg::REP_W-1:0]       n_rep_last;
    logic [pvrd_pkg::REP_W-1:0]       r_rep_last;
    logic                             w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid & i_cfg.ready;

    assign w_vol    = (i_cfg.data > pvrd_pkg::VOL_MAX) ? pvrd_pkg::VOL_MAX : i_cfg.data;
    assign w_coarse = pvrd_pkg::FACTOR_W'(w_vol) * pvrd_pkg::FACTOR_W'(pvrd_pkg::VOL_COARSE);
    assign w_fine   = pvrd_pkg::FINE_PROD_W'(w_vol)
                    * pvrd_pkg::FINE_PROD_W'(pvrd_pkg::VOL_FINE);

    always_comb begin
        n_factor   = r_factor;
        n_mono     = r_mono;
        n_rep_last = r_rep_last;
        if (w_wr) begin
            case (i_cfg.index)
                pvrd_pkg::CFG_VOLUME: begin
                    n_factor = w_coarse
                             + pvrd_pkg::FACTOR_W'(w_fine >> pvrd_pkg::FINE_SHIFT);
                end
                pvrd_pkg::CFG_CHANNELS: begin
                    n_mono = (i_cfg.data[1:0] == pvrd_pkg::CHAN_MONO);
                end
                pvrd_pkg::CFG_RATE: begin
                    case (i_cfg.data[1:0])
                        pvrd_pkg::RATE_22K05:  n_rep_last = pvrd_pkg::REP_TWO;
                        pvrd_pkg::RATE_11K025: n_rep_last = pvrd_pkg::REP_FOUR;
                        default:               n_rep_last = pvrd_pkg::REP_ONE;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor   <= pvrd_pkg::FACTOR_RST;
            r_mono     <= 1'b0;
            r_rep_last <= pvrd_pkg::REP_ONE;
        end else begin
            r_factor   <= n_factor;
            r_mono     <= n_mono;
            r_rep_last <= n_rep_last;
        end
    end

    assign o_cfg.factor   = r_factor;
    assign o_cfg.mono     = r_mono;
    assign o_cfg.rep_last = r_rep_last;

endmodule

@@ sv/pvrd_scale.sv @@
// Q15 volume multiply of one stereo pair; the floor comes from dropping the
// low product bits. Depends on pvrd_pkg.
module pvrd_scale (
    input  pvrd_pkg::t_pair               i_pair,
    input  logic [pvrd_pkg::FACTOR_W-1:0] i_factor,
    output pvrd_pkg::t_pair               o_pair
);

    logic signed [pvrd_pkg::FACTOR_W:0] w_factor;
    logic signed [pvrd_pkg::PROD_W-1:0] w_prod_l;
    logic signed [pvrd_pkg::PROD_W-1:0] w_prod_r;

    assign w_factor = $signed({1'b0, i_factor});
    assign w_prod_l = i_pair.left * w_factor;
    assign w_prod_r = i_pair.right * w_factor;

    assign o_pair.left  = w_prod_l[pvrd_pkg::Q15_SHIFT +: pvrd_pkg::SAMPLE_WIDTH];
    assign o_pair.right = w_prod_r[pvrd_pkg::Q15_SHIFT +: pvrd_pkg::SAMPLE_WIDTH];

endmodule

@@ sv/pvrd_rep.sv @@
// Input register and repeating result register of the volume scaler; the
// scaler sits between them. Depends on pvrd_pkg, pvrd_if and the macro header.
`include "pcm_volume_and_rate_doubler_top_defines.svh"

module pvrd_rep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pvrd_in_if.sink              i_in,
    pvrd_out_if.source           o_out,
    input  pvrd_pkg::t_cfg       i_cfg,
    output pvrd_pkg::t_pair      o_raw,
    input  pvrd_pkg::t_pair      i_scaled
);

    logic                         r_s_vld;
    logic                         n_s_vld;
    pvrd_pkg::t_pair              r_s_pair;
    pvrd_pkg::t_pair              n_s_pair;
    logic                         r_s_eob;
    logic                         n_s_eob;
    logic [pvrd_pkg::REP_W-1:0]   r_s_rep;
    logic [pvrd_pkg::REP_W-1:0]   n_s_rep;

    logic                         r_o_vld;
    logic                         n_o_vld;
    pvrd_pkg::t_pair              r_o_pair;
    pvrd_pkg::t_pair              n_o_pair;
    logic                         r_o_eob;
    logic                         n_o_eob;
    logic [pvrd_pkg::REP_W-1:0]   r_o_cnt;
    logic [pvrd_pkg::REP_W-1:0]   n_o_cnt;

    logic                         w_out_fire;
    logic                         w_out_free;
    logic                         w_load;
    logic                         w_in_fire;

    assign w_out_fire  = r_o_vld & o_out.ready;
    assign w_out_free  = !r_o_vld | (w_out_fire & (r_o_cnt == pvrd_pkg::REP_ONE));
    assign w_load      = r_s_vld & w_out_free;
    assign i_in.ready  = !r_s_vld | w_load;
    assign w_in_fire   = i_in.valid & i_in.ready;

    always_comb begin
        n_s_vld  = r_s_vld;
        n_s_pair = r_s_pair;
        n_s_eob  = r_s_eob;
        n_s_rep  = r_s_rep;
        if (w_in_fire) begin
            n_s_vld        = 1'b1;
            n_s_pair.left  = i_in.left_sample;
            n_s_pair.right = i_cfg.mono ? i_in.left_sample : i_in.right_sample;
            n_s_eob        = i_in.end_of_block;
            n_s_rep        = i_cfg.rep_last;
        end else if (w_load) begin
            n_s_vld = 1'b0;
        end
    end

    always_comb begin
        n_o_vld  = r_o_vld;
        n_o_pair = r_o_pair;
        n_o_eob  = r_o_eob;
        n_o_cnt  = r_o_cnt;
        if (w_load) begin
            n_o_vld  = 1'b1;
            n_o_pair = i_scaled;
            n_o_eob  = r_s_eob;
            n_o_cnt  = r_s_rep;
        end else if (w_out_fire) begin
            if (r_o_cnt == pvrd_pkg::REP_ONE) begin
                n_o_vld = 1'b0;
            end else begin
                n_o_cnt = r_o_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_s_rep <= pvrd_pkg::REP_ONE;
            r_o_cnt <= pvrd_pkg::REP_ONE;
        end else begin
            r_s_vld <= n_s_vld;
            r_o_vld <= n_o_vld;
            r_s_rep <= n_s_rep;
            r_o_cnt <= n_o_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_pair <= n_s_pair;
        r_s_eob  <= n_s_eob;
        r_o_pair <= n_o_pair;
        r_o_eob  <= n_o_eob;
    end

    assign o_raw           = r_s_pair;
    assign o_out.valid     = r_o_vld;
    assign o_out.left_out  = r_o_pair.left;
    assign o_out.right_out = r_o_pair.right;
    assign o_out.run_last  = (r_o_cnt == pvrd_pkg::REP_ONE);
    assign o_out.block_end = r_o_eob & (r_o_cnt == pvrd_pkg::REP_ONE);

    `PVRD_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load, r_o_vld, "loaded frame not shown")
    `PVRD_ASSERT_NEXT(a_stall_holds_cnt, i_clk, i_rst_n, r_o_vld && !o_out.ready,
        r_o_vld && $stable(r_o_cnt), "repeat count moved under stall")
    `PVRD_ASSERT_NEXT(a_cnt_steps, i_clk, i_rst_n,
        w_out_fire && (r_o_cnt != pvrd_pkg::REP_ONE) && !w_load,
        r_o_vld && (r_o_cnt == $past(r_o_cnt) - 1'b1), "repeat count skipped")
    `PVRD_ASSERT_NEXT(a_stage_kept, i_clk, i_rst_n, r_s_vld && !w_load,
        r_s_vld, "input stage dropped")
    `PVRD_ASSERT_NOW(a_no_load_midrun, i_clk, i_rst_n,
        w_load && r_o_vld, w_out_fire && (r_o_cnt == pvrd_pkg::REP_ONE),
        "run overwritten")

endmodule
